// File: hdl/trinucleotide_context_tracker_top_assert.svh
// ----------------------------------------------------------------------------
// trinucleotide_context_tracker_top_assert.svh: assertion macros
// Each use expands to one labeled concurrent assertion on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef TRINUCLEOTIDE_CONTEXT_TRACKER_TOP_ASSERT_SVH
`define TRINUCLEOTIDE_CONTEXT_TRACKER_TOP_ASSERT_SVH

// Same-cycle implication.
`define TCT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define TCT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/tct_pkg.sv
// ----------------------------------------------------------------------------
// tct_pkg: types and constants of the trinucleotide context tracker
// Beat layouts, base codes and the character and context lookups.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tct_pkg;

  typedef enum logic {
    OP_FEED    = 1'b0,
    OP_RESTART = 1'b1
  } op_t;

  // Window base codes.
  typedef logic [2:0] base_t;
  localparam base_t BASE_A = 3'd0;
  localparam base_t BASE_C = 3'd1;
  localparam base_t BASE_G = 3'd2;
  localparam base_t BASE_T = 3'd3;
  localparam base_t BASE_N = 3'd4;

  localparam logic [5:0] COMP_FLIP = 6'b10_10_10;
  localparam logic [6:0] INDEX_MAX = 7'd124;

  typedef struct packed {
    op_t        op;
    logic [7:0] char_in;
  } item_t;

  typedef struct packed {
    logic       accepted;
    logic [6:0] window_index;
    logic       is_context;
    logic [5:0] context_code;
    logic [5:0] complement_code;
  } result_t;

  typedef struct packed {
    logic  ok;
    base_t base;
  } decode_t;

  // Case-insensitive ACGTN decode; anything else is not ok.
  function automatic decode_t char_to_base(input logic [7:0] c);
    decode_t d;
    d.ok   = 1'b1;
    d.base = BASE_N;
    unique case (c)
      8'h41, 8'h61: d.base = BASE_A;
      8'h43, 8'h63: d.base = BASE_C;
      8'h47, 8'h67: d.base = BASE_G;
      8'h54, 8'h74: d.base = BASE_T;
      8'h4E, 8'h6E: d.base = BASE_N;
      default:      d.ok   = 1'b0;
    endcase
    return d;
  endfunction

  // Context symbol: C0 T1 G2 A3.
  function automatic logic [1:0] ctx_of_base(input base_t b);
    logic [1:0] s;
    unique case (b[1:0])
      2'd0:    s = 2'd3;
      2'd1:    s = 2'd0;
      2'd2:    s = 2'd2;
      default: s = 2'd1;
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

// File: hdl/trinucleotide_context_tracker_top.sv
// ----------------------------------------------------------------------------
// trinucleotide_context_tracker_top: three-base sliding window tracker
// Usage:
//   item channel (item_valid / item_stall / item): one beat carries op and an
//   ASCII character. op feed shifts a case-insensitive A/C/G/T/N into the
//   three-base window; other characters are rejected and leave it unchanged.
//   op restart refills the window with NNN.
//   result channel (result_valid / result_stall / result): one beat per item,
//   describing the window after that item.
// Output: registered; result_valid rises in the cycle after an item is accepted.
// Throughput: one item per cycle while item_stall is low; the window register and the result
//   register update in the same edge, so back-to-back items flow freely.
// Stall: the result register holds while result_stall is high; item_stall
//   follows it only when the result register is full, so an item is taken
//   in the same cycle the pending result leaves.
// Reset: window returns to NNN, result register empties.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "trinucleotide_context_tracker_top_assert.svh"

module trinucleotide_context_tracker_top
  import tct_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    item_valid,
  output logic         item_stall,
  input  wire item_t   item,
  output logic         result_valid,
  input  wire logic    result_stall,
  output result_t      result
);

  base_t   window [3];
  base_t   window_next [3];
  logic    take;
  logic    ok_next;
  decode_t dec;
  result_t result_next;
  logic    all_def;
  logic [1:0] s0, s1, s2;

  assign item_stall = result_valid && result_stall;
  assign take       = item_valid && !item_stall;

  always_comb begin
    dec            = char_to_base(item.char_in);
    window_next[0] = window[0];
    window_next[1] = window[1];
    window_next[2] = window[2];
    ok_next        = 1'b0;
    unique case (item.op)
      OP_RESTART: begin
        window_next[0] = BASE_N;
        window_next[1] = BASE_N;
        window_next[2] = BASE_N;
        ok_next        = 1'b1;
      end
      default: begin
        if (dec.ok) begin
          window_next[0] = window[1];
          window_next[1] = window[2];
          window_next[2] = dec.base;
          ok_next        = 1'b1;
        end
      end
    endcase
  end

  always_comb begin
    all_def = !window_next[0][2] && !window_next[1][2] && !window_next[2][2];
    s0      = ctx_of_base(window_next[0]);
    s1      = ctx_of_base(window_next[1]);
    s2      = ctx_of_base(window_next[2]);
    result_next.accepted     = ok_next;
    // 25a + 5b + c, all as shifts and adds on 7 bits
    result_next.window_index = {window_next[0], 4'b0} + {1'b0, window_next[0], 3'b0}
                             + {4'b0, window_next[0]} + {2'b0, window_next[1], 2'b0}
                             + {4'b0, window_next[1]} + {4'b0, window_next[2]};
    result_next.is_context   = all_def;
    result_next.context_code = all_def ? {s1, s2, s0} : 6'd0;
    result_next.complement_code = all_def ? ({s1, s2, s0} ^ COMP_FLIP) : 6'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window[0]    <= BASE_N;
      window[1]    <= BASE_N;
      window[2]    <= BASE_N;
      result_valid <= 1'b0;
    end else begin
      if (take) begin
        window[0]    <= window_next[0];
        window[1]    <= window_next[1];
        window[2]    <= window_next[2];
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      result <= result_next;
    end
  end

  `TCT_ASSERT_NOW(a_codes_pair, result_valid && result.is_context,
    (result.context_code ^ result.complement_code) == COMP_FLIP,
    "complement code does not match context code")
  `TCT_ASSERT_NOW(a_no_ctx_zero, result_valid && !result.is_context,
    result.context_code == 6'd0 && result.complement_code == 6'd0,
    "codes nonzero outside a context")
  `TCT_ASSERT_NEXT(a_restart, take && item.op == OP_RESTART,
    result_valid && result.accepted && result.window_index == INDEX_MAX,
    "restart did not give an NNN window")

endmodule

`default_nettype wire
